/* design/bsd_pkg.sv */
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared widths, types and helper functions of the base-b sum digit emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

  localparam int OPERAND_BITS = 31;
  localparam int MAX_DIGITS   = 32;

  localparam int SUM_BITS = OPERAND_BITS + 1;
  localparam int RADIX_W  = 6;
  localparam int DIGIT_W  = 6;
  localparam int CHAR_W   = 7;
  localparam int CNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W    = $clog2(MAX_DIGITS);
  localparam int STEP_W   = $clog2(SUM_BITS);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_LOWER = CHAR_W'(8'h61);
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH,
    ST_EMIT
  } bsd_state_t;

  // Control of the serial divider: load a new dividend or do one step.
  typedef struct packed {
    logic load;
    logic step;
  } bsd_div_ctrl_t;

  // Values below two act as base two, values above thirty-six as base 36.
  function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    else if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // ASCII character of a digit: '0'-'9', then 'a'-'z'.
  function automatic logic [CHAR_W-1:0] digit_char_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_DIGITS) res = CHAR_ZERO + CHAR_W'(d);
    else res = CHAR_LOWER + CHAR_W'(d - DEC_DIGITS);
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/bsd_divider.sv */
// ----------------------------------------------------------------------------
// bsd_divider
// Restoring divider by the radix, one quotient bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_divider (
  input  wire                                 clk,
  input  wire bsd_pkg::bsd_div_ctrl_t         ctrl,
  input  wire logic [bsd_pkg::SUM_BITS-1:0]   dividend,
  input  wire logic [bsd_pkg::RADIX_W-1:0]    radix,
  output logic      [bsd_pkg::SUM_BITS-1:0]   quotient,
  output logic      [bsd_pkg::DIGIT_W-1:0]    remainder
);
  import bsd_pkg::*;

  logic [DIGIT_W:0]   trial;
  logic [DIGIT_W:0]   diff;
  logic               fits;
  logic [DIGIT_W-1:0] remainder_next;

  // The dividend shifts out at the top while quotient bits shift in below.
  assign trial = {remainder, quotient[SUM_BITS-1]};
  assign diff  = trial - {1'b0, radix};
  assign fits  = (trial >= {1'b0, radix});
  assign remainder_next = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (ctrl.step) begin
      quotient  <= {quotient[SUM_BITS-2:0], fits};
      remainder <= remainder_next;
    end
  end

endmodule

`default_nettype wire

/* design/bsd_digit_stack.sv */
// ----------------------------------------------------------------------------
// bsd_digit_stack
// Shift-register stack of digits: pushed least significant first, popped
// most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_digit_stack (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                push,
  input  wire                                pop,
  input  wire logic [bsd_pkg::DIGIT_W-1:0]   push_digit,
  output logic      [bsd_pkg::DIGIT_W-1:0]   top_digit,
  output logic                               top_last
);
  import bsd_pkg::*;

  logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];
  logic [CNT_W-1:0]   digit_count;

  assign top_digit = digit_store[0];
  assign top_last  = (digit_count == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (push) begin
      digit_store[0] <= push_digit;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        digit_store[i] <= digit_store[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        digit_store[i] <= digit_store[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
    end else if (push) begin
      digit_count <= digit_count + CNT_W'(1);
    end else if (pop) begin
      digit_count <= digit_count - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

/* design/base_b_sum_digit_emitter.sv */
// ----------------------------------------------------------------------------
// base_b_sum_digit_emitter
// Adds two non-negative operands and writes the sum in a base from 2 to 36,
// one digit item at a time, most significant digit first.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Contents
// s_*       in   one item: first_operand, second_operand
// m_*       out  one digit item: digit_value, digit_char; tlast = last_digit
// radix_*   in   write of the radix register (reset value 10)
//
// An accepted item first passes through the serial dividers for each digit:
// a DIVIDE state that takes one quotient bit per step for every bit of the sum,
// then a FINISH state that stacks the digit and reloads the dividers. The
// digits then leave at one digit per cycle while the sink keeps m_tready
// high; a run has n digits, where n is one more than the base-b length of
// the longer operand.
// Reset is synchronous and clears the control state, the stack count, the output valid flag and the radix register.
// A stalled sink holds the digit in the output register; once the last digit
// has left the stack the block takes the next item while that digit waits.
// ----------------------------------------------------------------------------
`default_nettype none

module base_b_sum_digit_emitter (
  input  wire                                 clk,
  input  wire                                 rst,
  // Configuration: radix register.
  input  wire                                 radix_we,
  input  wire logic [bsd_pkg::RADIX_W-1:0]    radix_wdata,
  // Input items. tdata, lowest bit up: first_operand[30:0],
  // second_operand[61:31], zero padding[63:62].
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire logic [63:0]                    s_tdata,
  // Digit items. tdata, lowest bit up: digit_value[5:0], digit_char[12:6],
  // zero padding[15:13]. tlast carries last_digit.
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic      [15:0]                    m_tdata,
  output logic                                m_tlast
);
  import bsd_pkg::*;

  bsd_state_t state, state_next;

  logic [RADIX_W-1:0]  radix;
  logic [RADIX_W-1:0]  base;
  logic [STEP_W-1:0]   bit_cnt;
  logic [IDX_W-1:0]    digit_idx;
  logic                m_was_zero;

  logic [OPERAND_BITS-1:0] first_operand;
  logic [OPERAND_BITS-1:0] second_operand;
  logic [SUM_BITS-1:0]     sum;
  logic [SUM_BITS-1:0]     longer;

  bsd_div_ctrl_t       div_ctrl;
  logic [SUM_BITS-1:0] sum_dividend;
  logic [SUM_BITS-1:0] len_dividend;
  logic [SUM_BITS-1:0] sum_quot;
  logic [SUM_BITS-1:0] len_quot;
  logic [DIGIT_W-1:0]  sum_rem;
  logic [DIGIT_W-1:0]  len_rem;
  logic [RADIX_W-1:0]  div_radix;

  logic                push;
  logic                pop;
  logic                run_done;
  logic [DIGIT_W-1:0]  top_digit;
  logic                top_last;

  logic [DIGIT_W-1:0]  digit_value;
  logic [CHAR_W-1:0]   digit_char;

  assign first_operand  = s_tdata[OPERAND_BITS-1:0];
  assign second_operand = s_tdata[2*OPERAND_BITS-1:OPERAND_BITS];
  assign sum    = {1'b0, first_operand} + {1'b0, second_operand};
  assign longer = (first_operand > second_operand) ? {1'b0, first_operand}
                                                   : {1'b0, second_operand};

  // On acceptance the dividers take the operands; later they take their own
  // quotients back for the next digit.
  assign sum_dividend = (state == ST_IDLE) ? sum : sum_quot;
  assign len_dividend = (state == ST_IDLE) ? longer : len_quot;
  assign div_radix    = (state == ST_IDLE) ? effective_radix(radix) : base;

  // The run ends once the longer operand has been divided down to zero before
  // a step (that step gives the extra leading digit), but never on the first
  // digit, since an operand of zero still counts as one digit. The stack
  // depth bounds the run in any case.
  assign run_done = ((digit_idx != '0) && m_was_zero)
                 || (digit_idx == IDX_W'(MAX_DIGITS - 1));

  // One divider yields the digits of the sum; the other walks the longer
  // operand down to find the length of the run.
  bsd_divider u_sum_div (
    .clk       (clk),
    .ctrl      (div_ctrl),
    .dividend  (sum_dividend),
    .radix     (div_radix),
    .quotient  (sum_quot),
    .remainder (sum_rem)
  );

  bsd_divider u_len_div (
    .clk       (clk),
    .ctrl      (div_ctrl),
    .dividend  (len_dividend),
    .radix     (div_radix),
    .quotient  (len_quot),
    .remainder (len_rem)
  );

  bsd_digit_stack u_stack (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .push_digit (sum_rem),
    .top_digit  (top_digit),
    .top_last   (top_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    div_ctrl.load = 1'b0;
    div_ctrl.step = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          div_ctrl.load = 1'b1;
          state_next    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        div_ctrl.step = 1'b1;
        if (bit_cnt == STEP_W'(SUM_BITS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        push = 1'b1;
        if (run_done) begin
          state_next = ST_EMIT;
        end else begin
          div_ctrl.load = 1'b1;
          state_next    = ST_DIVIDE;
        end
      end
      ST_EMIT: begin
        pop = !m_tvalid || m_tready;
        if (pop && top_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath bookkeeping for the division loop.
  always_ff @(posedge clk) begin
    if (div_ctrl.load) begin
      bit_cnt    <= '0;
      m_was_zero <= (len_dividend == '0);
    end else if (div_ctrl.step) begin
      bit_cnt <= bit_cnt + STEP_W'(1);
    end
    if (state == ST_IDLE) begin
      digit_idx <= '0;
      base      <= effective_radix(radix);
    end else if (push && !run_done) begin
      digit_idx <= digit_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (radix_we) begin
      radix <= radix_wdata;
    end
  end

  // Output register: refilled from the stack during emission whenever it is empty or taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      digit_value <= top_digit;
      digit_char  <= digit_char_of(top_digit);
      m_tlast     <= top_last;
    end
  end

  assign m_tdata = {3'b000, digit_char, digit_value};

  // The remainder of the length divider plays no part in the result.
  logic len_rem_unused;
  assign len_rem_unused = ^len_rem;

endmodule

`default_nettype wire
